// File: hw/rtl/mfgs_pkg.sv
// Shared types and constants for the mains failure generator sequencer.
// Used by the core and by its checker; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfgs_pkg;

    localparam int TIMER_W = 16;
    localparam int TICKS_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] DRV_OFF   = 8'h00;
    localparam logic [7:0] DRV_MAINS = 8'h03;
    localparam logic [7:0] DRV_RUN   = 8'h80;
    localparam logic [7:0] DRV_CRANK = 8'hC0;
    localparam logic [7:0] DRV_GEN   = 8'h8F;
    localparam logic [7:0] DRV_BUZZ  = 8'h10;

    localparam logic [7:0]         QUALIFY_RST    = 8'd10;
    localparam logic [TICKS_W-1:0] RUN_DELAY_RST  = 16'd100;
    localparam logic [TICKS_W-1:0] CRANK_RST      = 16'd5000;
    localparam logic [TICKS_W-1:0] REST_RST       = 16'd10000;
    localparam logic [3:0]         ATTEMPTS_RST   = 4'd3;
    localparam logic [TICKS_W-1:0] ALARM_HALF_RST = 16'd1000;
    localparam logic [TICKS_W-1:0] RETRANSFER_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUALIFY    = 3'd0,
        REG_RUN_DELAY  = 3'd1,
        REG_CRANK      = 3'd2,
        REG_REST       = 3'd3,
        REG_ATTEMPTS   = 3'd4,
        REG_ALARM_HALF = 3'd5,
        REG_RETRANSFER = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_STARTUP    = 3'd0,
        PH_MAINS      = 3'd1,
        PH_RUN_DELAY  = 3'd2,
        PH_CRANK      = 3'd3,
        PH_REST       = 3'd4,
        PH_GEN_SUPPLY = 3'd5,
        PH_RETRANSFER = 3'd6
    } phase_t;

    typedef struct packed {
        logic mains_pin;
        logic genset_pin;
    } tick_item_t;

    typedef struct packed {
        logic [7:0] drive_word;
        logic [2:0] phase;
        logic       mains_present;
        logic       genset_running;
        logic [3:0] attempts_used;
    } result_item_t;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Clamp a configured length to what the phase timer can reach.
    function automatic logic [TIMER_W-1:0] timer_limit(input logic [TICKS_W-1:0] len);
        logic [TIMER_W-1:0] lim;
        if (32'(len) > 32'(TIMER_MAX))
        begin
            lim = TIMER_MAX;
        end
        else
        begin
            lim = TIMER_W'(len);
        end
        return lim;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mains_failure_genset_sequencer_core.sv
// Top level of the mains failure generator sequencer: sample qualification,
// phase sequencing and the result register. Depends on mfgs_pkg.
// Latency: a result appears in the cycle after its tick item is accepted.
// Throughput: one tick item per cycle while results are taken; the single
// state-update stage between the accepted item and the result register sets that figure.
// Reset: rst_n clears the sequencer to startup with all outputs off and loads
// the default register values; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module mains_failure_genset_sequencer_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            tick_valid,
    output logic                                 tick_ready,
    input  wire mfgs_pkg::tick_item_t            tick,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output mfgs_pkg::result_item_t               result,
    input  wire logic                            cfg_we,
    input  wire logic [mfgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mfgs_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [7:0]                   qualify_reg;
    logic [mfgs_pkg::TICKS_W-1:0] run_delay_reg;
    logic [mfgs_pkg::TICKS_W-1:0] crank_reg;
    logic [mfgs_pkg::TICKS_W-1:0] rest_reg;
    logic [3:0]                   attempts_max_reg;
    logic [mfgs_pkg::TICKS_W-1:0] alarm_half_len_reg;
    logic [mfgs_pkg::TICKS_W-1:0] retransfer_reg;

    // Sequencer state.
    mfgs_pkg::phase_t             phase_reg, phase_next;
    logic [mfgs_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [3:0]                   attempt_reg, attempt_next;
    logic [7:0]                   mains_cnt_reg, mains_cnt_next;
    logic [7:0]                   gen_cnt_reg, gen_cnt_next;
    logic [7:0]                   drive_reg, drive_next;
    logic                         alarm_half_reg, alarm_half_next;
    logic                         alarm_active_reg, alarm_active_next;

    logic                         result_valid_reg;
    mfgs_pkg::result_item_t       result_reg, result_next;

    logic accept;
    logic mains_ok;
    logic gen_ok;

    assign tick_ready   = !result_valid_reg || result_ready;
    assign accept       = tick_valid && tick_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qualify_reg        <= mfgs_pkg::QUALIFY_RST;
            run_delay_reg      <= mfgs_pkg::RUN_DELAY_RST;
            crank_reg          <= mfgs_pkg::CRANK_RST;
            rest_reg           <= mfgs_pkg::REST_RST;
            attempts_max_reg   <= mfgs_pkg::ATTEMPTS_RST;
            alarm_half_len_reg <= mfgs_pkg::ALARM_HALF_RST;
            retransfer_reg     <= mfgs_pkg::RETRANSFER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfgs_pkg::REG_QUALIFY:    qualify_reg        <= cfg_data[7:0];
                mfgs_pkg::REG_RUN_DELAY:  run_delay_reg      <= cfg_data;
                mfgs_pkg::REG_CRANK:      crank_reg          <= cfg_data;
                mfgs_pkg::REG_REST:       rest_reg           <= cfg_data;
                mfgs_pkg::REG_ATTEMPTS:   attempts_max_reg   <= cfg_data[3:0];
                mfgs_pkg::REG_ALARM_HALF: alarm_half_len_reg <= cfg_data;
                mfgs_pkg::REG_RETRANSFER: retransfer_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        logic [mfgs_pkg::TIMER_W-1:0] t;
        logic                         done;

        mains_cnt_next = tick.mains_pin
                       ? ((mains_cnt_reg == 8'hFF) ? mains_cnt_reg : mains_cnt_reg + 8'd1)
                       : 8'd0;
        gen_cnt_next   = !tick.genset_pin
                       ? ((gen_cnt_reg == 8'hFF) ? gen_cnt_reg : gen_cnt_reg + 8'd1)
                       : 8'd0;
        mains_ok = mains_cnt_next >= qualify_reg;
        gen_ok   = gen_cnt_next >= qualify_reg;

        phase_next        = phase_reg;
        attempt_next      = attempt_reg;
        drive_next        = drive_reg;
        alarm_half_next   = alarm_half_reg;
        alarm_active_next = alarm_active_reg;

        // The timer advances with saturation in every timed phase.
        t          = (timer_reg == mfgs_pkg::TIMER_MAX) ? timer_reg
                                                         : timer_reg + 1'b1;
        timer_next = t;
        done       = 1'b0;

        case (phase_reg)
            mfgs_pkg::PH_STARTUP, mfgs_pkg::PH_RETRANSFER:
            begin
                done = (phase_reg == mfgs_pkg::PH_STARTUP)
                     ? (t >= mfgs_pkg::timer_limit(run_delay_reg))
                     : (t >= mfgs_pkg::timer_limit(retransfer_reg));
                if (done)
                begin
                    timer_next = '0;
                    if (mains_ok)
                    begin
                        phase_next = mfgs_pkg::PH_MAINS;
                        drive_next = mfgs_pkg::DRV_MAINS;
                    end
                    else
                    begin
                        phase_next        = mfgs_pkg::PH_RUN_DELAY;
                        drive_next        = mfgs_pkg::DRV_RUN;
                        attempt_next      = 4'd0;
                        alarm_active_next = 1'b0;
                        alarm_half_next   = 1'b0;
                    end
                end
            end
            mfgs_pkg::PH_MAINS:
            begin
                timer_next = timer_reg;
                if (!mains_ok)
                begin
                    phase_next        = mfgs_pkg::PH_RUN_DELAY;
                    drive_next        = mfgs_pkg::DRV_RUN;
                    timer_next        = '0;
                    attempt_next      = 4'd0;
                    alarm_active_next = 1'b0;
                    alarm_half_next   = 1'b0;
                end
            end
            mfgs_pkg::PH_RUN_DELAY, mfgs_pkg::PH_REST:
            begin
                done = (phase_reg == mfgs_pkg::PH_RUN_DELAY)
                     ? (t >= mfgs_pkg::timer_limit(run_delay_reg))
                     : (t >= mfgs_pkg::timer_limit(rest_reg));
                if (done)
                begin
                    timer_next = '0;
                    if (attempts_max_reg == 4'd0 ||
                        (phase_reg == mfgs_pkg::PH_REST &&
                         (mains_ok || gen_ok || attempt_reg >= attempts_max_reg)))
                    begin
                        phase_next = mfgs_pkg::PH_GEN_SUPPLY;
                        drive_next = mfgs_pkg::DRV_RUN;
                    end
                    else
                    begin
                        phase_next   = mfgs_pkg::PH_CRANK;
                        drive_next   = mfgs_pkg::DRV_CRANK;
                        attempt_next = attempt_reg + 4'd1;
                    end
                end
            end
            mfgs_pkg::PH_CRANK:
            begin
                if (t >= mfgs_pkg::timer_limit(crank_reg))
                begin
                    phase_next = mfgs_pkg::PH_REST;
                    drive_next = mfgs_pkg::DRV_RUN;
                    timer_next = '0;
                end
            end
            mfgs_pkg::PH_GEN_SUPPLY:
            begin
                if (!alarm_active_reg && mains_ok)
                begin
                    phase_next = mfgs_pkg::PH_RETRANSFER;
                    drive_next = mfgs_pkg::DRV_OFF;
                    timer_next = '0;
                end
                else if (!alarm_active_reg && gen_ok)
                begin
                    drive_next = mfgs_pkg::DRV_GEN;
                    timer_next = timer_reg;
                end
                else
                begin
                    // A fresh alarm cycle restarts the timer, and its first tick counts.
                    if (!alarm_active_reg)
                    begin
                        t               = {{(mfgs_pkg::TIMER_W-1){1'b0}}, 1'b1};
                        alarm_half_next = 1'b0;
                    end
                    alarm_active_next = 1'b1;
                    timer_next        = t;
                    if (t >= mfgs_pkg::timer_limit(alarm_half_len_reg))
                    begin
                        timer_next = '0;
                        if (!alarm_half_next)
                        begin
                            alarm_half_next = 1'b1;
                            drive_next      = drive_reg | mfgs_pkg::DRV_BUZZ;
                        end
                        else
                        begin
                            alarm_half_next   = 1'b0;
                            alarm_active_next = 1'b0;
                            drive_next        = mfgs_pkg::DRV_OFF;
                            if (mains_ok)
                            begin
                                phase_next = mfgs_pkg::PH_RETRANSFER;
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = mfgs_pkg::PH_STARTUP;
                drive_next = mfgs_pkg::DRV_OFF;
                timer_next = '0;
            end
        endcase

        result_next.drive_word     = drive_next;
        result_next.phase          = phase_next;
        result_next.mains_present  = mains_ok;
        result_next.genset_running = gen_ok;
        result_next.attempts_used  = attempt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= mfgs_pkg::PH_STARTUP;
            timer_reg        <= '0;
            attempt_reg      <= 4'd0;
            mains_cnt_reg    <= 8'd0;
            gen_cnt_reg      <= 8'd0;
            drive_reg        <= mfgs_pkg::DRV_OFF;
            alarm_half_reg   <= 1'b0;
            alarm_active_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                timer_reg        <= timer_next;
                attempt_reg      <= attempt_next;
                mains_cnt_reg    <= mains_cnt_next;
                gen_cnt_reg      <= gen_cnt_next;
                drive_reg        <= drive_next;
                alarm_half_reg   <= alarm_half_next;
                alarm_active_reg <= alarm_active_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mfgs_checker.sv
// Port-level checker for the mains failure generator sequencer core, bound to
// the top level. Depends on mfgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfgs_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   tick_valid,
    input wire logic                   tick_ready,
    input wire logic                   result_valid,
    input wire logic                   result_ready,
    input wire mfgs_pkg::result_item_t result
);

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // Every accepted tick item yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> result_valid)
        else $error("accepted item produced no result");

    // On mains the relays are the only outputs driven.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.phase == mfgs_pkg::PH_MAINS |->
            result.drive_word == mfgs_pkg::DRV_MAINS)
        else $error("wrong outputs while on mains");

    // Cranking always counts an attempt and drives starter plus run line.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.phase == mfgs_pkg::PH_CRANK |->
            result.drive_word == mfgs_pkg::DRV_CRANK && result.attempts_used != 4'd0)
        else $error("crank phase with wrong outputs or no attempt counted");

    // The retransfer pause keeps everything off.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.phase == mfgs_pkg::PH_RETRANSFER |->
            result.drive_word == mfgs_pkg::DRV_OFF)
        else $error("outputs driven during retransfer pause");

endmodule

bind mains_failure_genset_sequencer_core mfgs_checker u_mfgs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// File: verif/mains_failure_genset_sequencer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for mains_failure_genset_sequencer_core. It sends tick items
// and predicts each result item with its own model of the sequencer.
// Depends on mfgs_pkg and the core RTL.

module mains_failure_genset_sequencer_core_tb;
    import mfgs_pkg::*;

    typedef struct {
        tick_item_t pins;
        int         gap_after;
        bit         wait_drain;
    } queued_tick_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  tick_valid = 1'b0;
    logic                  tick_ready;
    tick_item_t            tick = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_item_t          result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register values as the sequencer should see them.
    logic [7:0]  qualify_n      = QUALIFY_RST;
    logic [15:0] run_delay_len  = RUN_DELAY_RST;
    logic [15:0] crank_len      = CRANK_RST;
    logic [15:0] rest_len       = REST_RST;
    logic [3:0]  crank_limit    = ATTEMPTS_RST;
    logic [15:0] alarm_half_len = ALARM_HALF_RST;
    logic [15:0] retransfer_len = RETRANSFER_RST;

    // Predicted sequencer state.
    phase_t             seq_phase     = PH_STARTUP;
    logic [TIMER_W-1:0] phase_count   = '0;
    logic [3:0]         crank_count   = '0;
    logic [7:0]         mains_streak  = '0;
    logic [7:0]         genset_streak = '0;
    logic [7:0]         drive_image   = DRV_OFF;
    bit                 alarm_on      = 1'b0;
    bit                 alarm_second  = 1'b0;

    queued_tick_t tick_backlog[$];
    result_item_t due_results[$];
    int ticks_taken = 0;
    int results_taken = 0;
    int mismatches = 0;
    int gap_left = 0;
    int hold_left = 0;

    mains_failure_genset_sequencer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("[mains_failure_genset_sequencer_core] ERROR");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Steps the phase timer; true on the tick that completes a phase of len ticks,
    // so a length of zero still takes one tick.
    function automatic bit phase_timer_done(input logic [15:0] len);
        if (phase_count != TIMER_MAX)
            phase_count = phase_count + 1'b1;
        return phase_count >= len;
    endfunction

    function automatic void enter_phase(input phase_t ph, input logic [7:0] drv);
        seq_phase = ph;
        phase_count = '0;
        drive_image = drv;
    endfunction

    function automatic void start_failure();
        crank_count = '0;
        alarm_on = 1'b0;
        alarm_second = 1'b0;
        enter_phase(PH_RUN_DELAY, DRV_RUN);
    endfunction

    function automatic void start_crank();
        crank_count = crank_count + 1'b1;
        enter_phase(PH_CRANK, DRV_CRANK);
    endfunction

    function automatic void advance_sequencer(input tick_item_t t);
        bit           mains_ok;
        bit           gen_ok;
        bit           settled;
        result_item_t r;
        settled = 1'b0;
        if (t.mains_pin)
        begin
            if (mains_streak != 8'hFF)
                mains_streak = mains_streak + 1'b1;
        end
        else
            mains_streak = '0;
        // The generator sense pin is active low.
        if (!t.genset_pin)
        begin
            if (genset_streak != 8'hFF)
                genset_streak = genset_streak + 1'b1;
        end
        else
            genset_streak = '0;
        mains_ok = mains_streak >= qualify_n;
        gen_ok = genset_streak >= qualify_n;

        case (seq_phase)
            PH_STARTUP, PH_RETRANSFER:
            begin
                if (phase_timer_done(seq_phase == PH_STARTUP ? run_delay_len : retransfer_len))
                begin
                    if (mains_ok)
                        enter_phase(PH_MAINS, DRV_MAINS);
                    else
                        start_failure();
                end
            end
            PH_MAINS:
            begin
                if (!mains_ok)
                    start_failure();
            end
            PH_RUN_DELAY:
            begin
                if (phase_timer_done(run_delay_len))
                begin
                    if (crank_limit == 4'd0)
                        enter_phase(PH_GEN_SUPPLY, DRV_RUN);
                    else
                        start_crank();
                end
            end
            PH_CRANK:
            begin
                if (phase_timer_done(crank_len))
                    enter_phase(PH_REST, DRV_RUN);
            end
            PH_REST:
            begin
                if (phase_timer_done(rest_len))
                begin
                    if (mains_ok || gen_ok || crank_count >= crank_limit)
                        enter_phase(PH_GEN_SUPPLY, DRV_RUN);
                    else
                        start_crank();
                end
            end
            PH_GEN_SUPPLY:
            begin
                if (!alarm_on)
                begin
                    if (mains_ok)
                    begin
                        enter_phase(PH_RETRANSFER, DRV_OFF);
                        settled = 1'b1;
                    end
                    else if (gen_ok)
                    begin
                        drive_image = DRV_GEN;
                        settled = 1'b1;
                    end
                    else
                    begin
                        // A new alarm cycle starts, and this tick already counts.
                        alarm_on = 1'b1;
                        alarm_second = 1'b0;
                        phase_count = '0;
                    end
                end
                if (!settled && phase_timer_done(alarm_half_len))
                begin
                    phase_count = '0;
                    if (!alarm_second)
                    begin
                        alarm_second = 1'b1;
                        drive_image = drive_image | DRV_BUZZ;
                    end
                    else
                    begin
                        alarm_second = 1'b0;
                        alarm_on = 1'b0;
                        drive_image = DRV_OFF;
                        if (mains_ok)
                            enter_phase(PH_RETRANSFER, DRV_OFF);
                    end
                end
            end
            default:
                enter_phase(PH_STARTUP, DRV_OFF);
        endcase

        r.drive_word = drive_image;
        r.phase = seq_phase;
        r.mains_present = mains_ok;
        r.genset_running = gen_ok;
        r.attempts_used = crank_count;
        due_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want, got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sender side: offers items from the backlog with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        queued_tick_t next_tick;
        bit           taken;
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            taken = tick_valid && tick_ready;
            if (taken)
            begin
                advance_sequencer(tick);
                ticks_taken <= ticks_taken + 1;
            end
            if (!tick_valid || tick_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    tick_valid <= 1'b0;
                end
                else if (tick_backlog.size() == 0 ||
                         (tick_backlog[0].wait_drain &&
                          ticks_taken + int'(taken) != results_taken))
                    tick_valid <= 1'b0;
                else
                begin
                    next_tick = tick_backlog.pop_front();
                    tick <= next_tick.pins;
                    tick_valid <= 1'b1;
                    gap_left = next_tick.gap_after;
                end
            end
        end
    end

    // Receiver side: checks each result item and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        result_item_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item arrived with no tick item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("drive_word", want.drive_word, result.drive_word);
                    check_field("phase", 8'(want.phase), 8'(result.phase));
                    check_field("mains_present", 8'(want.mains_present),
                                8'(result.mains_present));
                    check_field("genset_running", 8'(want.genset_running),
                                8'(result.genset_running));
                    check_field("attempts_used", 8'(want.attempts_used),
                                8'(result.attempts_used));
                end
                // Two long holds let the core back up and stall its input.
                if (results_taken == 300 || results_taken == 900)
                    hold_left = 150;
                results_taken <= results_taken + 1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                hold_left = ((results_taken / 128) % 4 == 1) ? 0 : idle_len();
            end
        end
    end

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (tick_backlog.size() != 0 || tick_valid || ticks_taken != results_taken);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic apply_settings(input logic [7:0] q, input logic [15:0] rd, cr, rs,
                                  input logic [3:0] at, input logic [15:0] al, rt);
        wait_until_drained();
        write_reg(REG_QUALIFY, 16'(q));
        write_reg(REG_RUN_DELAY, rd);
        write_reg(REG_CRANK, cr);
        write_reg(REG_REST, rs);
        write_reg(REG_ATTEMPTS, 16'(at));
        write_reg(REG_ALARM_HALF, al);
        write_reg(REG_RETRANSFER, rt);
        @(posedge clk);
        cfg_we <= 1'b0;
        qualify_n = q;
        run_delay_len = rd;
        crank_len = cr;
        rest_len = rs;
        crank_limit = at;
        alarm_half_len = al;
        retransfer_len = rt;
    endtask

    // Queues len items at fixed pin levels, with an occasional single-sample glitch.
    task automatic queue_segment(input bit m, input bit g, input int len, input bit calm,
                                 input int glitch_pct);
        queued_tick_t qt;
        for (int i = 0; i < len; i++)
        begin
            qt.pins.mains_pin = m;
            qt.pins.genset_pin = g;
            if ($urandom_range(0, 99) < glitch_pct)
            begin
                if ($urandom_range(0, 1))
                    qt.pins.mains_pin = !m;
                else
                    qt.pins.genset_pin = !g;
            end
            qt.gap_after = calm ? 0 : idle_len();
            qt.wait_drain = (i == 0) && !calm && ($urandom_range(0, 99) < 2);
            tick_backlog.push_back(qt);
        end
    endtask

    task automatic queue_random(input int count, input int span);
        int len;
        while (count > 0)
        begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, span) : $urandom_range(1, 3);
            if (len > count)
                len = count;
            queue_segment(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len,
                          $urandom_range(0, 3) == 0, 3);
            count -= len;
        end
    endtask

    initial
    begin
        int         span;
        int         cr;
        int         rs;
        logic [7:0] q;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values, every pin combination.
        for (int c = 0; c < 4; c++)
            queue_segment(c[1], c[0], 1, 1'b1, 0);

        // Zero qualify samples: both flags read as present whatever the pins do.
        apply_settings(8'd0, 16'd0, 16'd0, 16'd0, 4'd0, 16'd0, 16'd0);
        queue_segment(1'b0, 1'b1, 1, 1'b1, 0);
        queue_segment(1'b1, 1'b0, 1, 1'b1, 0);

        // Zero attempts: run delay goes straight to generator supply and the alarm.
        apply_settings(8'd1, 16'd0, 16'd0, 16'd0, 4'd0, 16'd1, 16'd0);
        queue_segment(1'b0, 1'b1, 5, 1'b1, 0);
        queue_segment(1'b1, 1'b1, 2, 1'b1, 0);
        queue_segment(1'b0, 1'b0, 3, 1'b1, 0);

        // Most attempts with short timers, then the generator comes up.
        apply_settings(8'd2, 16'd1, 16'd1, 16'd1, 4'd15, 16'd1, 16'd1);
        queue_segment(1'b0, 1'b1, 6, 1'b1, 0);
        queue_segment(1'b0, 1'b0, 3, 1'b1, 0);

        for (int k = 0; k < 6; k++)
        begin
            q = 8'($urandom_range(1, 4));
            cr = $urandom_range(0, 6);
            rs = $urandom_range(0, 6);
            apply_settings(q, 16'($urandom_range(0, 6)), 16'(cr), 16'(rs),
                           (k == 5) ? 4'd15 : 4'($urandom_range(0, 4)),
                           16'($urandom_range(0, 5)), 16'($urandom_range(0, 6)));
            span = 4 * q + 3 * (cr + rs) + 8;
            queue_random(150, (span > 60) ? 60 : span);
        end

        // Longest qualification: mains held high long enough to saturate the count.
        apply_settings(8'd255, 16'd2, 16'd3, 16'd3, 4'd15, 16'd4, 16'd65535);
        queue_segment(1'b1, 1'b0, 280, 1'b0, 0);
        queue_random(60, 30);

        apply_settings(8'd255, 16'd65535, 16'd65535, 16'd65535, 4'd15, 16'd65535, 16'd65535);
        queue_random(40, 20);

        apply_settings(8'd1, 16'd0, 16'd1, 16'd1, 4'd1, 16'd1, 16'd0);
        queue_random(150, 20);

        wait_until_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("[mains_failure_genset_sequencer_core] OK");
        else
            $display("[mains_failure_genset_sequencer_core] ERROR");
        $finish;
    end

endmodule
